// ===== hdl/bfei_pkg.sv =====
`timescale 1ns / 1ps

package bfei_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned IDX_W  = 7;   // holds a bit count from 0 to WORD_W
  localparam int unsigned POS_W  = 6;   // bit index inside a word
  localparam int unsigned ARG_W  = 32;  // width of position and length
  localparam int unsigned KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_EXT_U32 = 3'd0,
    KIND_EXT_U64 = 3'd1,
    KIND_EXT_S32 = 3'd2,
    KIND_EXT_S64 = 3'd3,
    KIND_INS32   = 3'd4,
    KIND_INS64   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    OP_EXT_U = 2'd0,
    OP_EXT_S = 2'd1,
    OP_INS   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Decode stage output
  typedef struct packed {
    op_e                op;
    logic               is64;
    logic               pos_big;   // position at or past the word width
    logic               len_zero;
    logic               sign_w;    // top bit of the word
    logic [POS_W-1:0]   pos;
    logic [IDX_W-1:0]   flen;      // field length clipped to the word top
    logic [IDX_W-1:0]   fend;      // pos + flen
    logic [WORD_W-1:0]  base;      // already cut to the word width
    logic [WORD_W-1:0]  ins;
  } dec_t;

  // Shift stage output
  typedef struct packed {
    op_e                op;
    logic               is64;
    logic               pos_big;
    logic               len_zero;
    logic               sign_w;
    logic [IDX_W-1:0]   flen;
    logic [WORD_W-1:0]  base;
    logic [WORD_W-1:0]  sh;        // base >> pos
    logic [WORD_W-1:0]  ins_sh;    // ins << pos
    logic [WORD_W-1:0]  fmask;     // low flen bits
    logic [WORD_W-1:0]  imask;     // bits pos .. pos+flen-1
  } shf_t;

  function automatic logic [WORD_W-1:0] low_bits(input logic [IDX_W-1:0] n);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = (IDX_W'(i) < n);
    end
    return m;
  endfunction

endpackage

// ===== hdl/bit_field_extract_insert_unit.sv =====
`timescale 1ns / 1ps

// Bit-field extract/insert unit. Each input word selects one of six
// operations in tuser (unsigned or signed extract, or insert, at 32 or 64
// bits) and yields exactly one 64-bit result word; 32-bit kinds return their
// value in bits 31:0 with bits 63:32 zero. The unit takes one word per clock
// while the output is not stalled and hands the result out through its
// register stages: decode and field clipping, the barrel shifters with mask
// build, and the final merge into the output register. Each stage holds its
// word on a stall and fills bubbles ahead of it, so input is still taken
// while a result waits at the output, as long as some stage is empty.

module bit_field_extract_insert_unit
  import bfei_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // tdata: base_word[63:0], insert_value[127:64], position[159:128],
  //        length[191:160]
  input  logic [191:0]  s_axis_tdata_i,
  // tuser: kind[2:0]
  input  logic [2:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // tdata: result_word[63:0]
  output logic [63:0]   m_axis_tdata_o
);

  logic dec_valid;
  logic dec_ready;
  dec_t dec;
  logic shf_valid;
  logic shf_ready;
  shf_t shf;

  bfei_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .kind_i  (s_axis_tuser_i),
    .base_i  (s_axis_tdata_i[63:0]),
    .ins_i   (s_axis_tdata_i[127:64]),
    .pos_i   (s_axis_tdata_i[159:128]),
    .len_i   (s_axis_tdata_i[191:160]),
    .valid_o (dec_valid),
    .ready_i (dec_ready),
    .dec_o   (dec)
  );

  bfei_shift u_shift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .dec_i   (dec),
    .valid_o (shf_valid),
    .ready_i (shf_ready),
    .shf_o   (shf)
  );

  bfei_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (shf_valid),
    .ready_o  (shf_ready),
    .shf_i    (shf),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (m_axis_tdata_o)
  );

endmodule

// ===== hdl/bfei_decode.sv =====
`timescale 1ns / 1ps

module bfei_decode
  import bfei_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [WORD_W-1:0] base_i,
  input  logic [WORD_W-1:0] ins_i,
  input  logic [ARG_W-1:0]  pos_i,
  input  logic [ARG_W-1:0]  len_i,
  output logic              valid_o,
  input  logic              ready_i,
  output dec_t              dec_o
);

  logic             valid_q;
  dec_t             dec_q;
  dec_t             dec_d;
  logic [ARG_W-1:0] len_eff;
  logic [IDX_W-1:0] room;

  always_comb begin
    dec_d = '0;
    case (kind_e'(kind_i))
      KIND_EXT_U32: begin dec_d.op = OP_EXT_U; dec_d.is64 = 1'b0; end
      KIND_EXT_U64: begin dec_d.op = OP_EXT_U; dec_d.is64 = 1'b1; end
      KIND_EXT_S32: begin dec_d.op = OP_EXT_S; dec_d.is64 = 1'b0; end
      KIND_EXT_S64: begin dec_d.op = OP_EXT_S; dec_d.is64 = 1'b1; end
      KIND_INS32:   begin dec_d.op = OP_INS;   dec_d.is64 = 1'b0; end
      KIND_INS64:   begin dec_d.op = OP_INS;   dec_d.is64 = 1'b1; end
      default:      begin dec_d.op = OP_NONE;  dec_d.is64 = 1'b0; end
    endcase

    // 32-bit kinds look at the low byte of position and length only
    if (dec_d.is64) begin
      dec_d.pos_big = |pos_i[ARG_W-1:POS_W];
      dec_d.pos     = pos_i[POS_W-1:0];
      len_eff       = len_i;
      room          = IDX_W'(WORD_W) - {1'b0, pos_i[POS_W-1:0]};
      dec_d.base    = base_i;
      dec_d.sign_w  = base_i[WORD_W-1];
    end else begin
      dec_d.pos_big = |pos_i[7:POS_W-1];
      dec_d.pos     = {1'b0, pos_i[POS_W-2:0]};
      len_eff       = {{(ARG_W-8){1'b0}}, len_i[7:0]};
      room          = IDX_W'(HALF_W) - {2'b00, pos_i[POS_W-2:0]};
      dec_d.base    = {{HALF_W{1'b0}}, base_i[HALF_W-1:0]};
      dec_d.sign_w  = base_i[HALF_W-1];
    end

    dec_d.len_zero = (len_eff == '0);
    // clip the field at the top of the word
    dec_d.flen = (len_eff >= {{(ARG_W-IDX_W){1'b0}}, room}) ? room : len_eff[IDX_W-1:0];
    dec_d.fend = {1'b0, dec_d.pos} + dec_d.flen;
    dec_d.ins  = ins_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

// ===== hdl/bfei_shift.sv =====
`timescale 1ns / 1ps

module bfei_shift
  import bfei_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  dec_t dec_i,
  output logic valid_o,
  input  logic ready_i,
  output shf_t shf_o
);

  logic valid_q;
  shf_t shf_q;
  shf_t shf_d;

  always_comb begin
    shf_d.op       = dec_i.op;
    shf_d.is64     = dec_i.is64;
    shf_d.pos_big  = dec_i.pos_big;
    shf_d.len_zero = dec_i.len_zero;
    shf_d.sign_w   = dec_i.sign_w;
    shf_d.flen     = dec_i.flen;
    shf_d.base     = dec_i.base;
    shf_d.sh       = dec_i.base >> dec_i.pos;
    shf_d.ins_sh   = dec_i.ins << dec_i.pos;
    shf_d.fmask    = low_bits(dec_i.flen);
    shf_d.imask    = low_bits(dec_i.fend) & ~low_bits({1'b0, dec_i.pos});
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      shf_q <= shf_d;
    end
  end

  assign valid_o = valid_q;
  assign shf_o   = shf_q;

endmodule

// ===== hdl/bfei_merge.sv =====
`timescale 1ns / 1ps

module bfei_merge
  import bfei_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  shf_t              shf_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [WORD_W-1:0] result_o
);

  logic              valid_q;
  logic [WORD_W-1:0] result_q;
  logic [WORD_W-1:0] result_d;
  logic [WORD_W-1:0] wmask;
  logic [IDX_W-1:0]  top;
  logic              sign;

  always_comb begin
    wmask = shf_i.is64 ? {WORD_W{1'b1}} : {{HALF_W{1'b0}}, {HALF_W{1'b1}}};
    top   = shf_i.flen - IDX_W'(1);
    sign  = (shf_i.flen != '0) && shf_i.sh[top[POS_W-1:0]];
    case (shf_i.op)
      OP_EXT_U: begin
        result_d = shf_i.pos_big ? '0 : (shf_i.sh & shf_i.fmask);
      end
      OP_EXT_S: begin
        if (shf_i.len_zero) begin
          result_d = '0;
        end else if (shf_i.pos_big) begin
          result_d = {WORD_W{shf_i.sign_w}} & wmask;
        end else begin
          // sign-extend from the top bit of the clipped field
          result_d = ((shf_i.sh & shf_i.fmask) | (~shf_i.fmask & {WORD_W{sign}})) & wmask;
        end
      end
      OP_INS: begin
        result_d = shf_i.pos_big ? shf_i.base
                 : ((shf_i.base & ~shf_i.imask) | (shf_i.ins_sh & shf_i.imask));
      end
      default: begin
        result_d = '0;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== hdl/bfei_checker.sv =====
`timescale 1ns / 1ps

module bfei_assertions (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_i,
  input logic         m_axis_tvalid_i,
  input logic         m_axis_tready_i,
  input logic [63:0]  m_axis_tdata_i
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] cnt_q;
  logic [2:0] cnt_d;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_i;
  assign out_acc = m_axis_tvalid_i && m_axis_tready_i;

  // words accepted but not yet delivered
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("output word changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 3'd0) |-> !m_axis_tvalid_i)
    else $error("output word with nothing in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd3)
    else $error("more words in flight than pipeline stages");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_i)
    else $error("input blocked while output drains");

endmodule

bind bit_field_extract_insert_unit bfei_assertions u_bfei_assertions (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);
